// ===== rtl/core/skrp_pkg.sv =====
// Shared types and constants of the skyline rectangle packer.
// No dependencies.
package skrp_pkg;

  localparam int unsigned ROW_W = 32;
  localparam int unsigned DIM_W = 10;
  localparam int unsigned PAD_W = 11;

  localparam logic [ROW_W-1:0] ROW_MAX    = '1;
  localparam logic [DIM_W-1:0] ROWS_RESET = 10'd150;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FRAME  = 1'b1
  } op_e;

  typedef logic [ROW_W-1:0] row_t;

endpackage

// ===== rtl/core/skrp_store.sv =====
// Skyline corner point store: x and y arrays, one read and one write port.
// Entries 0 and 1 read as their reset values until written after reset or a clear. Uses skrp_pkg.
module skrp_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned XW    = 10,
  parameter int unsigned X1    = 1023
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [XW-1:0]            rd_x_o,
  output skrp_pkg::row_t           rd_y_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [XW-1:0]            wr_x_i,
  input  skrp_pkg::row_t           wr_y_i
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [XW-1:0]  x_mem [DEPTH];
  skrp_pkg::row_t y_mem [DEPTH];
  logic [XW-1:0]  x_q;
  skrp_pkg::row_t y_q;
  logic [AW-1:0]  addr_q;
  logic [1:0]     vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      x_mem[wr_addr_i] <= wr_x_i;
      y_mem[wr_addr_i] <= wr_y_i;
    end
    x_q    <= x_mem[rd_addr_i];
    y_q    <= y_mem[rd_addr_i];
    addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (we_i && wr_addr_i < AW'(2)) begin
      vld_q[wr_addr_i[0]] <= 1'b1;
    end
  end

  always_comb begin
    rd_x_o = x_q;
    rd_y_o = y_q;
    if (addr_q < AW'(2) && !vld_q[addr_q[0]]) begin
      rd_x_o = addr_q[0] ? XW'(X1) : '0;
      rd_y_o = '0;
    end
  end

endmodule

// ===== rtl/core/skyline_rect_packer.sv =====
// Skyline bottom-left rectangle packer for a rolling glyph atlas.
// Depends on skrp_pkg and skrp_store.
// An insert is bounded by the pair scan through the single read port; a frame
// reads every point twice: once for the extremes, once to raise them. One item at
// a time; the result register frees the input while a result waits.
// Reset: async active low; skyline back to two points, dirty range empty.
module skyline_rect_packer #(
  parameter int unsigned ATLAS_WIDTH = 1024,
  parameter int unsigned MAX_POINTS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_window_rows_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [9:0]  rect_width_i,
  input  logic [9:0]  rect_height_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        placed_o,
  output logic [9:0]  pos_x_o,
  output logic [31:0] pos_y_o,
  output logic        upload_valid_o,
  output logic [31:0] upload_first_o,
  output logic [31:0] upload_end_o
);

  localparam int unsigned XW = $clog2(ATLAS_WIDTH);
  localparam int unsigned PW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned KW = CW + 2;
  localparam int unsigned SW = ((XW > skrp_pkg::PAD_W) ? XW : skrp_pkg::PAD_W) + 1;
  localparam int unsigned RW = skrp_pkg::ROW_W;

  typedef enum logic [4:0] {
    S_IDLE, S_PI, S_PIW, S_E, S_EW, S_CHK, S_A, S_AW, S_SH, S_MR, S_MW,
    S_W0, S_W1, S_D0, S_D1, S_D2, S_FR, S_FRW, S_FBASE, S_F2R, S_F2W,
    S_FEND, S_DONE
  } state_e;

  state_e         st_q;
  logic [9:0]     rows_q;
  logic [CW-1:0]  n_q, i_q, e_q, best_q, adj_q, newn_q, src_q, dst_q;
  logic           desc_q, found_q;
  logic [XW-1:0]  xi_q, bx_q, dupx_q;
  skrp_pkg::row_t yi_q, off_q, byi_q, boff_q, by_q;
  logic [RW:0]    besty_q;
  logic [skrp_pkg::PAD_W-1:0] rw_q, rh_q;
  skrp_pkg::row_t line_top_q, dfirst_q, dend_q, top_q, low_q, base_q;
  logic           res_placed_q, res_up_q;
  logic [9:0]     res_x_q;
  skrp_pkg::row_t res_y_q, res_f_q, res_e_q;
  logic           out_valid_q;

  // store ports
  logic [PW-1:0]  raddr, waddr;
  logic           we, clr;
  logic [XW-1:0]  rd_x, wx;
  skrp_pkg::row_t rd_y, wy;

  // scan helpers
  logic [SW-1:0]  reach;
  logic [RW:0]    cand;
  skrp_pkg::row_t rise;
  logic [RW+1:0]  bottom, limit;

  assign reach  = SW'(xi_q) + SW'(rw_q);
  assign cand   = {1'b0, yi_q} + {1'b0, off_q};
  assign rise   = rd_y - yi_q;
  assign bottom = (RW+2)'(besty_q) + (RW+2)'(rh_q);
  assign limit  = (RW+2)'(line_top_q) + (RW+2)'(rows_q);

  skrp_store #(
    .DEPTH (MAX_POINTS),
    .XW    (XW),
    .X1    (ATLAS_WIDTH - 1)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .rd_addr_i (raddr),
    .rd_x_o    (rd_x),
    .rd_y_o    (rd_y),
    .we_i      (we),
    .wr_addr_i (waddr),
    .wr_x_i    (wx),
    .wr_y_i    (wy)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Read address per state; data comes back in the following state.
  // Moves read one entry and write it in the next state, and sources always
  // stay ahead of destinations, so no read hits a pending write.
  always_comb begin
    raddr = i_q[PW-1:0];
    unique case (st_q)
      S_E:     raddr = e_q[PW-1:0];
      S_A:     raddr = adj_q[PW-1:0];
      S_MR:    raddr = src_q[PW-1:0];
      S_D0:    raddr = PW'(newn_q - CW'(2));
      S_D1:    raddr = PW'(newn_q - CW'(1));
      default: raddr = i_q[PW-1:0];
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wx    = rd_x;
    wy    = rd_y;
    clr   = 1'b0;
    unique case (st_q)
      S_MW: begin
        we    = 1'b1;
        waddr = dst_q[PW-1:0];
      end
      S_W0: begin
        we    = 1'b1;
        waddr = best_q[PW-1:0];
        wx    = bx_q;
        wy    = by_q + RW'(rh_q);
      end
      S_W1: begin
        we    = 1'b1;
        waddr = PW'(best_q + CW'(1));
        wx    = XW'(SW'(bx_q) + SW'(rw_q));
        wy    = by_q;
      end
      S_F2W: begin
        // Raise low points to the base; the end marker always takes it.
        we    = (i_q == n_q - CW'(1)) || (rd_y < base_q);
        waddr = i_q[PW-1:0];
        wy    = base_q;
      end
      S_FEND: clr = (line_top_q >= skrp_pkg::ROW_MAX - RW'(rows_q));
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      rows_q       <= skrp_pkg::ROWS_RESET;
      n_q          <= CW'(2);
      line_top_q   <= '0;
      dfirst_q     <= skrp_pkg::ROW_MAX;
      dend_q       <= '0;
      out_valid_q  <= 1'b0;
      i_q <= '0; e_q <= '0; best_q <= '0; adj_q <= '0; newn_q <= '0;
      src_q <= '0; dst_q <= '0; desc_q <= 1'b0; found_q <= 1'b0;
      xi_q <= '0; bx_q <= '0; dupx_q <= '0; yi_q <= '0; off_q <= '0;
      byi_q <= '0; boff_q <= '0; by_q <= '0; besty_q <= '0;
      rw_q <= '0; rh_q <= '0; top_q <= '0; low_q <= '0; base_q <= '0;
      res_placed_q <= 1'b0; res_up_q <= 1'b0; res_x_q <= '0;
      res_y_q <= '0; res_f_q <= '0; res_e_q <= '0;
      placed_o <= 1'b0; pos_x_o <= '0; pos_y_o <= '0;
      upload_valid_o <= 1'b0; upload_first_o <= '0; upload_end_o <= '0;
    end else begin
      if (cfg_valid_i) begin
        rows_q <= cfg_window_rows_i;
      end
      // Load a new result or drop the accepted one.
      if (st_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_placed_q <= 1'b0; res_up_q <= 1'b0; res_x_q <= '0;
            res_y_q <= '0; res_f_q <= '0; res_e_q <= '0;
            i_q     <= '0;
            found_q <= 1'b0;
            rw_q    <= skrp_pkg::PAD_W'(rect_width_i) + skrp_pkg::PAD_W'(2);
            rh_q    <= skrp_pkg::PAD_W'(rect_height_i) + skrp_pkg::PAD_W'(2);
            if (operation_i == skrp_pkg::OP_FRAME) begin
              st_q <= S_FR;
            end else if (n_q > CW'(1)) begin
              st_q <= S_PI;
            end else begin
              st_q <= S_DONE;
            end
          end
        end
        S_PI: st_q <= S_PIW;
        S_PIW: begin
          xi_q  <= rd_x;
          yi_q  <= rd_y;
          e_q   <= i_q + CW'(1);
          off_q <= '0;
          st_q  <= S_E;
        end
        S_E: st_q <= S_EW;
        S_EW: begin
          if (SW'(rd_x) >= reach) begin
            // Fit: keep the lowest candidate, first wins on ties.
            if (!found_q || cand < besty_q) begin
              found_q <= 1'b1;
              besty_q <= cand;
              best_q  <= i_q;
              bx_q    <= xi_q;
              byi_q   <= yi_q;
              boff_q  <= off_q;
            end
            i_q  <= i_q + CW'(1);
            st_q <= (KW'(i_q) + KW'(2) < KW'(n_q)) ? S_PI : S_CHK;
          end else begin
            if (rd_y > yi_q && rise > off_q) begin
              off_q <= rise;
            end
            e_q <= e_q + CW'(1);
            if (KW'(e_q) + KW'(1) < KW'(n_q)) begin
              st_q <= S_E;
            end else begin
              i_q  <= i_q + CW'(1);
              st_q <= (KW'(i_q) + KW'(2) < KW'(n_q)) ? S_PI : S_CHK;
            end
          end
        end
        S_CHK: begin
          by_q  <= byi_q + boff_q;
          adj_q <= best_q;
          if (!found_q || bottom > limit) begin
            st_q <= S_DONE;
          end else begin
            st_q <= S_A;
          end
        end
        S_A: st_q <= S_AW;
        S_AW: begin
          // Skip points covered by the new rect.
          if (SW'(rd_x) < SW'(bx_q) + SW'(rw_q)) begin
            adj_q <= adj_q + CW'(1);
            st_q  <= (KW'(adj_q) + KW'(1) < KW'(n_q)) ? S_A : S_SH;
          end else begin
            st_q <= S_SH;
          end
        end
        S_SH: begin
          newn_q <= CW'(KW'(n_q) + KW'(best_q) + KW'(2) - KW'(adj_q));
          desc_q <= (KW'(adj_q) < KW'(best_q) + KW'(2));
          if (KW'(n_q) + KW'(best_q) + KW'(2) > KW'(MAX_POINTS) + KW'(adj_q)) begin
            st_q <= S_DONE;
          end else if (adj_q < n_q && KW'(adj_q) != KW'(best_q) + KW'(2)) begin
            if (KW'(adj_q) < KW'(best_q) + KW'(2)) begin
              // Grow: move the tail up, last entry first.
              src_q <= n_q - CW'(1);
              dst_q <= CW'(KW'(n_q) + KW'(best_q) + KW'(1) - KW'(adj_q));
            end else begin
              // Shrink: move the tail down, first entry first.
              src_q <= adj_q;
              dst_q <= best_q + CW'(2);
            end
            st_q <= S_MR;
          end else begin
            st_q <= S_W0;
          end
        end
        S_MR: st_q <= S_MW;
        S_MW: begin
          if (desc_q) begin
            src_q <= src_q - CW'(1);
            dst_q <= dst_q - CW'(1);
            st_q  <= (src_q > adj_q) ? S_MR : S_W0;
          end else begin
            src_q <= src_q + CW'(1);
            dst_q <= dst_q + CW'(1);
            st_q  <= (KW'(src_q) + KW'(1) < KW'(n_q)) ? S_MR : S_W0;
          end
        end
        S_W0: st_q <= S_W1;
        S_W1: st_q <= S_D0;
        S_D0: st_q <= S_D1;
        S_D1: begin
          dupx_q <= rd_x;
          st_q   <= S_D2;
        end
        S_D2: begin
          // Drop a duplicate tail point.
          n_q <= (rd_x == dupx_q) ? newn_q - CW'(1) : newn_q;
          if (by_q < dfirst_q) begin
            dfirst_q <= by_q;
          end
          if (by_q + RW'(rh_q) > dend_q) begin
            dend_q <= by_q + RW'(rh_q);
          end
          res_placed_q <= 1'b1;
          res_x_q      <= 10'(SW'(bx_q) + SW'(1));
          res_y_q      <= by_q + RW'(1);
          st_q         <= S_DONE;
        end
        S_FR: st_q <= S_FRW;
        S_FRW: begin
          if (i_q == '0) begin
            top_q <= rd_y;
            low_q <= rd_y;
          end else begin
            if (rd_y > top_q) top_q <= rd_y;
            if (rd_y < low_q) low_q <= rd_y;
          end
          i_q  <= i_q + CW'(1);
          st_q <= (KW'(i_q) + KW'(1) < KW'(n_q)) ? S_FR : S_FBASE;
        end
        S_FBASE: begin
          line_top_q <= top_q;
          if (top_q >= RW'(rows_q) && top_q - RW'(rows_q) > low_q) begin
            base_q <= top_q - RW'(rows_q);
          end else begin
            base_q <= low_q;
          end
          i_q  <= '0;
          st_q <= S_F2R;
        end
        S_F2R: st_q <= S_F2W;
        S_F2W: begin
          i_q  <= i_q + CW'(1);
          st_q <= (KW'(i_q) + KW'(1) < KW'(n_q)) ? S_F2R : S_FEND;
        end
        S_FEND: begin
          if (dfirst_q < dend_q) begin
            res_up_q <= 1'b1;
            res_f_q  <= dfirst_q;
            res_e_q  <= dend_q;
          end
          dfirst_q <= skrp_pkg::ROW_MAX;
          dend_q   <= '0;
          // Near row overflow: restart the skyline.
          if (line_top_q >= skrp_pkg::ROW_MAX - RW'(rows_q)) begin
            n_q        <= CW'(2);
            line_top_q <= '0;
          end
          st_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            placed_o       <= res_placed_q;
            pos_x_o        <= res_x_q;
            pos_y_o        <= res_y_q;
            upload_valid_o <= res_up_q;
            upload_first_o <= res_f_q;
            upload_end_o   <= res_e_q;
            st_q           <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for skyline_rect_packer: directed table, then random inserts and frames.
// A local skyline model predicts each result the table does not give. Depends on skrp_pkg and the packer RTL.
module tb;

  localparam int unsigned NPTS = 64;
  localparam int unsigned AW = 1024;
  localparam int unsigned WATCHDOG = 400000;

  typedef struct packed {
    logic           placed;
    logic [9:0]     pos_x;
    skrp_pkg::row_t pos_y;
    logic           up_valid;
    skrp_pkg::row_t up_first;
    skrp_pkg::row_t up_end;
  } result_t;

  typedef struct {
    skrp_pkg::op_e op;
    logic [9:0]    w;
    logic [9:0]    h;
    bit            typed;
    result_t       res;
  } row_stim_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [9:0]     cfg_window_rows_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  logic           operation_i = 1'b0;
  logic [9:0]     rect_width_i = '0;
  logic [9:0]     rect_height_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  logic           placed_o;
  logic [9:0]     pos_x_o;
  skrp_pkg::row_t pos_y_o;
  logic           upload_valid_o;
  skrp_pkg::row_t upload_first_o;
  skrp_pkg::row_t upload_end_o;

  skyline_rect_packer i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_window_rows_i,
    .in_valid_i, .in_ready_o, .operation_i, .rect_width_i, .rect_height_i,
    .out_valid_o, .out_ready_i, .placed_o, .pos_x_o, .pos_y_o,
    .upload_valid_o, .upload_first_o, .upload_end_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the skyline and the update window.
  int unsigned    sky_x [NPTS];
  skrp_pkg::row_t sky_y [NPTS];
  int unsigned    sky_n;
  skrp_pkg::row_t win_rows, top_line, win_base, dirty_lo, dirty_hi;

  result_t     pending_q[$];
  int          errors = 0;
  int          send_idle = 0;  // percent of cycles the sender holds off
  int          recv_idle = 0;  // percent of cycles the receiver stalls
  int unsigned quiet = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void sky_clear();
    for (int i = 0; i < NPTS; i++) begin
      sky_x[i] = 0;
      sky_y[i] = '0;
    end
    sky_x[1] = AW - 1;
    sky_n = 2;
    top_line = '0;
    win_base = '0;
  endfunction

  // Bottom-left fit over all skyline start points; splice on success.
  function automatic result_t place_rect(input int unsigned w, input int unsigned h);
    result_t        r;
    int unsigned    rw, rh, best, best_off, off, e, adj, newn;
    longint         fw, best_y, cand, shift;
    bit             found;
    int unsigned    tx [NPTS];
    skrp_pkg::row_t ty [NPTS];
    skrp_pkg::row_t bx, by;
    r = '0;
    rw = w + 2;
    rh = h + 2;
    found = 0;
    best = 0;
    best_off = 0;
    best_y = 0;
    for (int unsigned i = 0; i + 1 < sky_n; i++) begin
      e = i + 1;
      off = 0;
      fw = 0;
      while (e < sky_n) begin
        fw = longint'(sky_x[e]) - longint'(sky_x[i]);
        if (fw >= rw) break;
        if (sky_y[e] > sky_y[i] && sky_y[e] - sky_y[i] > off) off = sky_y[e] - sky_y[i];
        e++;
      end
      if (fw >= rw) begin
        cand = longint'(sky_y[i]) + off;
        if (!found || cand < best_y) begin
          found = 1;
          best_y = cand;
          best_off = off;
          best = i;
        end
      end
    end
    if (!found) return r;
    bx = sky_x[best];
    by = sky_y[best] + best_off;
    if (longint'(sky_y[best]) + best_off + rh > longint'(top_line) + longint'(win_rows))
      return r;
    adj = best;
    while (adj < sky_n && longint'(sky_x[adj]) < longint'(bx) + rw) adj++;
    shift = longint'(best) + 2 - longint'(adj);
    if (longint'(sky_n) + shift > NPTS) return r;
    newn = 32'(longint'(sky_n) + shift);
    tx = sky_x;
    ty = sky_y;
    for (int unsigned k = adj; k < sky_n; k++) begin
      sky_x[best + 2 + k - adj] = tx[k];
      sky_y[best + 2 + k - adj] = ty[k];
    end
    sky_x[best] = bx;
    sky_y[best] = by + rh;
    sky_x[best + 1] = bx + rw;
    sky_y[best + 1] = by;
    // drop a duplicate tail point
    if (newn >= 2 && sky_x[newn - 1] == sky_x[newn - 2]) newn--;
    sky_n = newn;
    if (by < dirty_lo) dirty_lo = by;
    if (by + rh > dirty_hi) dirty_hi = by + rh;
    r.placed = 1'b1;
    r.pos_x = 10'(bx + 1);
    r.pos_y = by + 1;
    return r;
  endfunction

  // Raise the skyline to the new window base and hand out the dirty range.
  function automatic result_t close_frame();
    result_t        r;
    skrp_pkg::row_t top, low, base;
    r = '0;
    top = sky_n ? sky_y[0] : '0;
    low = top;
    for (int unsigned i = 0; i < sky_n; i++) begin
      if (sky_y[i] > top) top = sky_y[i];
      if (sky_y[i] < low) low = sky_y[i];
    end
    top_line = top;
    base = low;
    if (top >= win_rows && top - win_rows > low) base = top - win_rows;
    for (int unsigned i = 0; i < sky_n; i++)
      if (sky_y[i] < base) sky_y[i] = base;
    if (sky_n) sky_y[sky_n - 1] = base;
    if (dirty_lo < dirty_hi) begin
      r.up_valid = 1'b1;
      r.up_first = dirty_lo;
      r.up_end = dirty_hi;
    end
    win_base = base;
    dirty_lo = skrp_pkg::ROW_MAX;
    dirty_hi = '0;
    // rows near 32-bit overflow: start the skyline over
    if (top_line >= skrp_pkg::ROW_MAX - win_rows) sky_clear();
    return r;
  endfunction

  // Drive one item, wait for acceptance, queue its expected result.
  task automatic send_item(input skrp_pkg::op_e op, input logic [9:0] w,
                           input logic [9:0] h, input bit typed, input result_t want);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    rect_width_i = w;
    rect_height_i = h;
    do @(posedge clk_i); while (!in_ready_o);
    r = (op == skrp_pkg::OP_INSERT) ? place_rect(w, h) : close_frame();
    pending_q = {pending_q, (typed ? want : r)};
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  // Write the window height only while the block is idle.
  task automatic set_window(input logic [9:0] rows);
    drain();
    repeat (20) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_window_rows_i = rows;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_rows = rows;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_phase(input int count, input bit hold_off);
    int          pick;
    logic [9:0]  w, h;
    for (int n = 0; n < count; n++) begin
      if (hold_off && n == count / 2) drain();
      pick = $urandom_range(99);
      if (pick < 14) begin
        send_item(skrp_pkg::OP_FRAME, 10'($urandom), 10'($urandom), 0, '0);
      end else begin
        if (pick < 22) begin
          w = 10'($urandom_range(1021));
          h = 10'($urandom_range(1021));
        end else begin
          w = 10'($urandom_range(60));
          h = 10'($urandom_range(40));
        end
        send_item(skrp_pkg::OP_INSERT, w, h, 0, '0);
      end
    end
  endtask

  // Receiver: stall at random, change ready at the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, queue depth", 0, 0);
      end else begin
        want = pending_q.pop_front();
        if (placed_o !== want.placed) report_mismatch("placed", placed_o, want.placed);
        if (pos_x_o !== want.pos_x) report_mismatch("pos_x", pos_x_o, want.pos_x);
        if (pos_y_o !== want.pos_y) report_mismatch("pos_y", pos_y_o, want.pos_y);
        if (upload_valid_o !== want.up_valid)
          report_mismatch("upload_valid", upload_valid_o, want.up_valid);
        if (upload_first_o !== want.up_first)
          report_mismatch("upload_first", upload_first_o, want.up_first);
        if (upload_end_o !== want.up_end)
          report_mismatch("upload_end", upload_end_o, want.up_end);
      end
    end
  end

  // Watchdog: count cycles with no handshake on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  row_stim_t plan [] = '{
    // fresh skyline: 2x2 padded cell at the origin
    '{skrp_pkg::OP_INSERT, 10'd0, 10'd0, 1, '{1'b1, 10'd1, 32'd1, 1'b0, 32'd0, 32'd0}},
    '{skrp_pkg::OP_FRAME, 10'd0, 10'd0, 1, '{1'b0, 10'd0, 32'd0, 1'b1, 32'd0, 32'd2}},
    // nothing placed since the last frame: empty dirty range
    '{skrp_pkg::OP_FRAME, 10'd0, 10'd0, 1, '{1'b0, 10'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    // full atlas width sits on top of the first cell
    '{skrp_pkg::OP_INSERT, 10'd1021, 10'd0, 1, '{1'b1, 10'd1, 32'd3, 1'b0, 32'd0, 32'd0}},
    // taller than the window allows
    '{skrp_pkg::OP_INSERT, 10'd0, 10'd1021, 1, '{1'b0, 10'd0, 32'd0, 1'b0, 32'd0, 32'd0}},
    '{skrp_pkg::OP_INSERT, 10'd1021, 10'd1021, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd5, 10'd3, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd682, 10'd21, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd341, 10'd42, 0, '0},
    '{skrp_pkg::OP_FRAME, 10'd1023, 10'd1023, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd1, 10'd1, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd1020, 10'd146, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd100, 10'd100, 0, '0},
    '{skrp_pkg::OP_FRAME, 10'd0, 10'd0, 0, '0},
    '{skrp_pkg::OP_INSERT, 10'd2, 10'd2, 0, '0},
    '{skrp_pkg::OP_FRAME, 10'd0, 10'd0, 0, '0}
  };

  initial begin
    win_rows = skrp_pkg::row_t'(skrp_pkg::ROWS_RESET);
    dirty_lo = skrp_pkg::ROW_MAX;
    dirty_hi = '0;
    sky_clear();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle = 9;
    recv_idle = 75;
    foreach (plan[k]) send_item(plan[k].op, plan[k].w, plan[k].h, plan[k].typed, plan[k].res);
    for (int k = 0; k < 30; k++) send_item(skrp_pkg::OP_INSERT, 10'd0, 10'd0, 0, '0);

    set_window(10'd1023);
    random_phase(200, 1);

    send_idle = 75;
    recv_idle = 9;
    set_window(10'd1);
    random_phase(60, 0);
    set_window(10'($urandom_range(1, 1023)));
    random_phase(140, 0);

    send_idle = 0;
    recv_idle = 0;
    set_window(10'd150);
    random_phase(200, 0);

    drain();
    repeat (50) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
